// ===== src/sssc_pkg.sv =====
`default_nettype none
package sssc_pkg;

    localparam int DIGITS = 8;
    localparam int ADDR_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int IDX_W = 3;
    localparam int NIB_W = 4 * DIGITS;
    localparam longint DEC_TOP = longint'(10) ** DIGITS;
    localparam longint DEC_MAX = DEC_TOP - 1;
    localparam longint DEC_MIN = -(DEC_TOP / 10 - 1);
    localparam int MAG_W = $clog2(DEC_TOP);
    localparam int CNT_W = $clog2(MAG_W);

    localparam logic [7:0] DASH = 8'h40;

    localparam logic [2:0] REQ_TICK = 3'd0;
    localparam logic [2:0] REQ_RAW = 3'd1;
    localparam logic [2:0] REQ_HEXD = 3'd2;
    localparam logic [2:0] REQ_HEXW = 3'd3;
    localparam logic [2:0] REQ_DEC = 3'd4;
    localparam logic [2:0] REQ_CLEAR = 3'd5;
    localparam logic [2:0] REQ_READ = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_WRITE,
        ST_SHIFT,
        ST_LATCH,
        ST_READ
    } state_t;

    typedef struct packed {
        logic              we;
        logic              clr;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } sssc_wr_t;

    function automatic logic [7:0] glyph(input logic [3:0] nib);
        logic [7:0] code;
        unique case (nib)
            4'h0: code = 8'hc0;
            4'h1: code = 8'hf9;
            4'h2: code = 8'ha4;
            4'h3: code = 8'hb0;
            4'h4: code = 8'h99;
            4'h5: code = 8'h92;
            4'h6: code = 8'h82;
            4'h7: code = 8'hf8;
            4'h8: code = 8'h80;
            4'h9: code = 8'h90;
            4'ha: code = 8'h88;
            4'hb: code = 8'h83;
            4'hc: code = 8'hc6;
            4'hd: code = 8'ha1;
            4'he: code = 8'h86;
            4'hf: code = 8'h8e;
            default: code = 8'hc0;
        endcase
        return ~code;
    endfunction

endpackage
`default_nettype wire

// ===== src/sssc_store.sv =====
`default_nettype none
module sssc_store import sssc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sssc_wr_t          wr,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]             rd_data
);

    logic [7:0] seg_reg [DIGITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIGITS; i++)
            begin
                seg_reg[i] <= '0;
            end
        end
        else if (wr.clr)
        begin
            for (int i = 0; i < DIGITS; i++)
            begin
                seg_reg[i] <= '0;
            end
        end
        else if (wr.we)
        begin
            seg_reg[wr.addr] <= wr.data;
        end
    end

    assign rd_data = seg_reg[rd_addr];

endmodule
`default_nettype wire

// ===== src/sssc_bcd_unit.sv =====
`default_nettype none
module sssc_bcd_unit import sssc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [MAG_W-1:0] mag,
    output logic                  done,
    output logic [NIB_W-1:0]      bcd
);

    logic [MAG_W-1:0] bin_reg;
    logic [MAG_W-1:0] bin_next;
    logic [NIB_W-1:0] bcd_reg;
    logic [NIB_W-1:0] bcd_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             run_reg;
    logic             run_next;
    logic             done_reg;
    logic             done_next;
    logic [NIB_W-1:0] adj;

    // Shift-and-add-three: every digit of five or more gets three added
    // before the whole word moves one place to the left.
    always_comb
    begin
        for (int d = 0; d < DIGITS; d++)
        begin
            adj[4*d +: 4] = (bcd_reg[4*d +: 4] >= 4'd5) ?
                            bcd_reg[4*d +: 4] + 4'd3 : bcd_reg[4*d +: 4];
        end
    end

    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            bin_next = mag;
            bcd_next = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            bcd_next = {adj[NIB_W-2:0], bin_reg[MAG_W-1]};
            bin_next = {bin_reg[MAG_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(MAG_W - 1))
            begin
                run_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd = bcd_reg;

endmodule
`default_nettype wire

// ===== src/seven_segment_scan_controller_unit.sv =====
`default_nettype none
// Eight-digit scan controller for a multiplexed seven-segment display. A tick
// request returns nine transfers: the eight segment bits of the digit under
// the scan index, most significant first, then a latch transfer marked last;
// it keeps the block busy, also through any output stall, until the latch
// transfer is taken. A read returns one transfer. Raw, hex digit and clear
// writes finish in the cycle they are accepted. A hex word write stores one
// digit per cycle. A decimal write runs a shift-and-add-three converter one
// bit per cycle over 27 bits and then stores one digit per cycle; an
// out-of-range value skips the conversion. No request is taken while one is
// still in progress.
module seven_segment_scan_controller_unit import sssc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [2:0]         req_type,
    input  wire logic [IDX_W-1:0]   digit_index,
    input  wire logic signed [31:0] value,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [2:0]              digit_select,
    output logic                    serial_bit,
    output logic                    latch,
    output logic [7:0]              read_data,
    output logic                    last
);

    state_t            state_reg;
    state_t            state_next;
    logic [2:0]        scan_reg;
    logic [2:0]        scan_next;
    logic [2:0]        sel_reg;
    logic [2:0]        sel_next;
    logic [7:0]        shift_reg;
    logic [7:0]        shift_next;
    logic [2:0]        bit_reg;
    logic [2:0]        bit_next;
    logic [NIB_W-1:0]  nib_reg;
    logic [NIB_W-1:0]  nib_next;
    logic [ADDR_W-1:0] k_reg;
    logic [ADDR_W-1:0] k_next;
    logic              dash_all_reg;
    logic              dash_all_next;
    logic              dash_first_reg;
    logic              dash_first_next;

    logic              in_fire;
    logic              out_fire;
    logic              idx_ok;
    logic              dec_out;
    logic [31:0]       abs_val;
    logic              bcd_start;
    logic              bcd_done;
    logic [NIB_W-1:0]  bcd;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;
    sssc_wr_t          wr;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_fire = in_valid && !in_stall;
    assign out_fire = out_valid && !out_stall;
    assign idx_ok = ({1'b0, digit_index} < (IDX_W + 1)'(DIGITS));
    assign dec_out = (longint'(value) > DEC_MAX) || (longint'(value) < DEC_MIN);
    assign abs_val = value[31] ? 32'(-value) : 32'(value);
    assign rd_addr = (req_type == REQ_TICK) ? scan_reg[ADDR_W-1:0]
                                            : digit_index[ADDR_W-1:0];

    sssc_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sssc_bcd_unit u_bcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (bcd_start),
        .mag   (abs_val[MAG_W-1:0]),
        .done  (bcd_done),
        .bcd   (bcd)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (req_type)
                        REQ_TICK: state_next = ST_SHIFT;
                        REQ_HEXW: state_next = ST_WRITE;
                        REQ_DEC:  state_next = dec_out ? ST_WRITE : ST_CONV;
                        REQ_READ: state_next = ST_READ;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CONV:
            begin
                if (bcd_done)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (k_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SHIFT:
            begin
                if (out_fire && bit_reg == 3'd7)
                begin
                    state_next = ST_LATCH;
                end
            end
            ST_LATCH, ST_READ:
            begin
                if (out_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        scan_next = scan_reg;
        sel_next = sel_reg;
        shift_next = shift_reg;
        bit_next = bit_reg;
        nib_next = nib_reg;
        k_next = k_reg;
        dash_all_next = dash_all_reg;
        dash_first_next = dash_first_reg;
        bcd_start = 1'b0;
        wr = '0;
        out_valid = 1'b0;
        digit_select = '0;
        serial_bit = 1'b0;
        latch = 1'b0;
        read_data = '0;
        last = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (req_type)
                        REQ_TICK:
                        begin
                            sel_next = scan_reg;
                            shift_next = rd_data;
                            bit_next = '0;
                        end
                        REQ_RAW:
                        begin
                            wr.we = idx_ok;
                            wr.addr = digit_index[ADDR_W-1:0];
                            wr.data = value[7:0];
                        end
                        REQ_HEXD:
                        begin
                            wr.we = idx_ok && !value[31];
                            wr.addr = digit_index[ADDR_W-1:0];
                            wr.data = glyph(value[3:0]);
                        end
                        REQ_HEXW:
                        begin
                            nib_next = value[NIB_W-1:0];
                            k_next = ADDR_W'(DIGITS - 1);
                            dash_all_next = 1'b0;
                            dash_first_next = 1'b0;
                        end
                        REQ_DEC:
                        begin
                            k_next = ADDR_W'(DIGITS - 1);
                            dash_all_next = dec_out;
                            dash_first_next = value[31];
                            bcd_start = !dec_out;
                        end
                        REQ_CLEAR:
                        begin
                            wr.clr = 1'b1;
                        end
                        REQ_READ:
                        begin
                            shift_next = idx_ok ? rd_data : 8'h00;
                        end
                        default:
                        begin
                            wr = '0;
                        end
                    endcase
                end
            end
            ST_CONV:
            begin
                if (bcd_done)
                begin
                    nib_next = bcd;
                end
            end
            ST_WRITE:
            begin
                wr.we = 1'b1;
                wr.addr = k_reg;
                wr.data = (dash_all_reg || (dash_first_reg && k_reg == '0)) ?
                          DASH : glyph(nib_reg[3:0]);
                nib_next = nib_reg >> 4;
                k_next = k_reg - 1'b1;
            end
            ST_SHIFT:
            begin
                out_valid = 1'b1;
                digit_select = sel_reg;
                serial_bit = shift_reg[7];
                if (out_fire)
                begin
                    shift_next = {shift_reg[6:0], 1'b0};
                    bit_next = bit_reg + 1'b1;
                end
            end
            ST_LATCH:
            begin
                out_valid = 1'b1;
                digit_select = sel_reg;
                latch = 1'b1;
                last = 1'b1;
                if (out_fire)
                begin
                    scan_next = (sel_reg == 3'(DIGITS - 1)) ? 3'd0 : sel_reg + 1'b1;
                end
            end
            ST_READ:
            begin
                out_valid = 1'b1;
                read_data = shift_reg;
                last = 1'b1;
            end
            default:
            begin
                wr = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            scan_reg <= '0;
            bit_reg <= '0;
            k_reg <= '0;
            dash_all_reg <= 1'b0;
            dash_first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            scan_reg <= scan_next;
            bit_reg <= bit_next;
            k_reg <= k_next;
            dash_all_reg <= dash_all_next;
            dash_first_reg <= dash_first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg <= sel_next;
        shift_reg <= shift_next;
        nib_reg <= nib_next;
    end

endmodule
`default_nettype wire
